>>> rtl/ptq_pkg.sv
// Shared types and constants for the periodic timer queue.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package ptq_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int MAX_RES       = 16;   // most entries that fire on one tick
  localparam int NOW_W         = 48;
  localparam int PER_W         = 40;
  localparam int SCALE_W       = 28;
  localparam int PROD_W        = 38;   // 10-bit count times 28-bit scale

  localparam logic [15:0] MS_PER_SECOND_RST = 16'd1000;
  localparam logic [21:0] MS_PER_MINUTE_RST = 22'd60000;
  localparam logic [27:0] MS_PER_HOUR_RST   = 28'd3600000;

  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_ONE_SHOT    = 2'd1;
  localparam logic [1:0] OP_FIXED_RATE  = 2'd2;
  localparam logic [1:0] OP_FIXED_DELAY = 2'd3;

  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  localparam logic [1:0] UNIT_SECOND = 2'd0;
  localparam logic [1:0] UNIT_MINUTE = 2'd1;

  localparam logic [1:0] CFG_MS_PER_SECOND = 2'd0;
  localparam logic [1:0] CFG_MS_PER_MINUTE = 2'd1;
  localparam logic [1:0] CFG_MS_PER_HOUR   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] task_id;
    logic [9:0] initial_delay;
    logic [9:0] period;
    logic [1:0] unit;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       task_id_out;
    logic [NOW_W-1:0] event_time;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       task_id;
    logic [NOW_W-1:0] deadline;
    logic [PER_W-1:0] period_ms;
  } slot_t;

endpackage

`default_nettype wire

>>> rtl/periodic_timer_queue.sv
// Periodic timer queue top level: control sequencer, slot valid bits, clock.
// Depends on ptq_pkg, ptq_arm and ptq_slot_mem.
`default_nettype none

// A schedule command holds busy high for one cycle and answers with one
// accepted or rejected beat. A tick holds busy high while the slot memory is
// swept once per firing entry and once more to find none (not when the limit
// of sixteen is reached), as it has a single read port and each sweep finds
// the next firing entry in deadline order. The next command can be taken
// at the edge after busy falls. Results come one beat per strobe and cannot be
// held off; busy stays high until the last beat of a command has been driven.
module periodic_timer_queue
  import ptq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W = $clog2(MAX_RES + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd,
  output logic             result_valid,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [27:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCHED  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_DECIDE = 6'b010000,
    S_LAST   = 6'b100000
  } state_t;

  state_t             state;
  logic [NOW_W-1:0]   now_ms;
  logic [SLOTS-1:0]   slot_valid;
  logic [SLOTS-1:0]   due;
  logic [15:0]        ms_per_second;
  logic [21:0]        ms_per_minute;
  logic [27:0]        ms_per_hour;
  cmd_t               cmd_q;
  logic [IDX_W-1:0]   free_q;
  logic               full_q;
  logic [IDX_W-1:0]   scan_idx;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               first_pass;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  slot_t              best;
  logic               pending_v;
  logic [7:0]         pending_task;
  logic [CNT_W-1:0]   fire_cnt;

  logic               accept;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [NOW_W-1:0]   arm_deadline;
  logic [PER_W-1:0]   arm_period;
  slot_t              rd_data;
  logic               rd_due;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  slot_t              mem_wdata;
  logic               best_periodic;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!free_found && !slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  ptq_arm u_arm (
    .clk           (clk),
    .load          (accept),
    .cmd           (cmd),
    .ms_per_second (ms_per_second),
    .ms_per_minute (ms_per_minute),
    .ms_per_hour   (ms_per_hour),
    .now_ms        (now_ms),
    .deadline      (arm_deadline),
    .period_ms     (arm_period)
  );

  ptq_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // The first sweep of a tick decides which entries are due; later sweeps
  // only look at the entries still marked due, whose deadlines are untouched.
  assign rd_due = first_pass ? (slot_valid[rd_idx] && (rd_data.deadline <= now_ms))
                             : due[rd_idx];

  assign best_periodic = (best.kind == OP_FIXED_RATE) || (best.kind == OP_FIXED_DELAY);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = best;
    if (state == S_SCHED) begin
      mem_we             = !full_q;
      mem_waddr          = free_q;
      mem_wdata.kind     = cmd_q.op;
      mem_wdata.task_id  = cmd_q.task_id;
      mem_wdata.deadline = arm_deadline;
      mem_wdata.period_ms = arm_period;
    end else if (state == S_DECIDE) begin
      mem_we = found && best_periodic;
      if (best.kind == OP_FIXED_RATE) begin
        mem_wdata.deadline = best.deadline + NOW_W'(best.period_ms);
      end else begin
        mem_wdata.deadline = now_ms + NOW_W'(best.period_ms);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      now_ms        <= '0;
      slot_valid    <= '0;
      due           <= '0;
      ms_per_second <= MS_PER_SECOND_RST;
      ms_per_minute <= MS_PER_MINUTE_RST;
      ms_per_hour   <= MS_PER_HOUR_RST;
      rd_vld        <= 1'b0;
      found         <= 1'b0;
      first_pass    <= 1'b0;
      pending_v     <= 1'b0;
      fire_cnt      <= '0;
      scan_idx      <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_vld       <= (state == S_SCAN);
      rd_idx       <= scan_idx;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MS_PER_SECOND: ms_per_second <= cfg_data[15:0];
          CFG_MS_PER_MINUTE: ms_per_minute <= cfg_data[21:0];
          CFG_MS_PER_HOUR:   ms_per_hour   <= cfg_data;
          default: ;
        endcase
      end

      if (rd_vld) begin
        if (first_pass) begin
          due[rd_idx] <= rd_due;
        end
        if (rd_due && (!found || (rd_data.deadline < best.deadline))) begin
          found    <= 1'b1;
          best_idx <= rd_idx;
          best     <= rd_data;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= cmd;
            free_q <= free_idx;
            full_q <= !free_found;
            if (cmd.op == OP_TICK) begin
              now_ms     <= now_ms + NOW_W'(1);
              first_pass <= 1'b1;
              found      <= 1'b0;
              pending_v  <= 1'b0;
              fire_cnt   <= '0;
              scan_idx   <= '0;
              state      <= S_SCAN;
            end else begin
              state <= S_SCHED;
            end
          end
        end
        S_SCHED: begin
          if (!full_q) begin
            slot_valid[free_q] <= 1'b1;
          end
          result_valid       <= 1'b1;
          result.kind        <= full_q ? KIND_REJECTED : KIND_ACCEPTED;
          result.task_id_out <= cmd_q.task_id;
          result.event_time  <= now_ms;
          result.last        <= 1'b1;
          state              <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_idx == IDX_W'(SLOTS - 1)) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          // The entry found by the previous sweep goes out now; it is the
          // final beat when this sweep found nothing further.
          if (pending_v) begin
            result_valid       <= 1'b1;
            result.kind        <= KIND_FIRED;
            result.task_id_out <= pending_task;
            result.event_time  <= now_ms;
            result.last        <= !found;
          end
          first_pass <= 1'b0;
          found      <= 1'b0;
          scan_idx   <= '0;
          if (found) begin
            due[best_idx] <= 1'b0;
            if (!best_periodic) begin
              slot_valid[best_idx] <= 1'b0;
            end
            pending_v    <= 1'b1;
            pending_task <= best.task_id;
            fire_cnt     <= fire_cnt + CNT_W'(1);
            if (fire_cnt == CNT_W'(MAX_RES - 1)) begin
              state <= S_LAST;
            end else begin
              state <= S_SCAN;
            end
          end else begin
            pending_v <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_LAST: begin
          result_valid       <= 1'b1;
          result.kind        <= KIND_FIRED;
          result.task_id_out <= pending_task;
          result.event_time  <= now_ms;
          result.last        <= 1'b1;
          pending_v          <= 1'b0;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A schedule answer is always the only beat of its command.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind != KIND_FIRED)) |-> result.last)
    else $error("schedule answer without last");

  // A tick moves the clock forward by exactly one millisecond.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.op == OP_TICK)) |=> (now_ms == $past(now_ms) + NOW_W'(1)))
    else $error("tick did not advance the clock by one");

  // No more than the fire limit per tick.
  assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= CNT_W'(MAX_RES))
    else $error("fire count above limit");

  // The slot memory is written only when storing or re-arming an entry.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_SCHED) || ((state == S_DECIDE) && found)))
    else $error("slot memory written outside store or re-arm");
`endif

endmodule

`default_nettype wire

>>> rtl/ptq_slot_mem.sv
// Slot table storage: one write port and one read port with registered data.
// Depends on ptq_pkg for the entry type.
`default_nettype none

module ptq_slot_mem
  import ptq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_t            wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_t                 rd_data
);

  slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/ptq_arm.sv
// Schedule arithmetic: scales delay and period by the selected unit, registers
// the products, then forms the deadline. Depends on ptq_pkg.
`default_nettype none

module ptq_arm
  import ptq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire cmd_t             cmd,
  input  wire logic [15:0]      ms_per_second,
  input  wire logic [21:0]      ms_per_minute,
  input  wire logic [27:0]      ms_per_hour,
  input  wire logic [NOW_W-1:0] now_ms,
  output logic [NOW_W-1:0]      deadline,
  output logic [PER_W-1:0]      period_ms
);

  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  delay_prod;
  logic [PROD_W-1:0]  period_prod;

  // Unit three falls through to hours.
  always_comb begin
    priority if (cmd.unit == UNIT_SECOND) begin
      scale = SCALE_W'(ms_per_second);
    end else if (cmd.unit == UNIT_MINUTE) begin
      scale = SCALE_W'(ms_per_minute);
    end else begin
      scale = ms_per_hour;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      delay_prod  <= PROD_W'(cmd.initial_delay) * PROD_W'(scale);
      period_prod <= (cmd.op == OP_ONE_SHOT) ? '0 : PROD_W'(cmd.period) * PROD_W'(scale);
    end
  end

  assign deadline  = now_ms + NOW_W'(delay_prod);
  assign period_ms = PER_W'(period_prod);

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for periodic_timer_queue: directed table, then random phases.
// Needs only ptq_pkg and the periodic_timer_queue RTL; results are checked
// against an in-bench copy of the timer table.
`timescale 1ns / 1ps

module testbench;
  import ptq_pkg::*;

  localparam int SLOTS           = SLOTS_DEFAULT;
  localparam int SETTLE_CYCLES   = 2 * (SLOTS + 2) + 4;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DIR_ROWS        = 16;
  localparam int CFG_ROW         = 5;    // registers change before this row
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 93;

  localparam logic [1:0] UNIT_HOUR  = 2'd2;
  localparam logic [1:0] UNIT_THREE = 2'd3;  // the block treats it as hours
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    cmd_t        c;
    logic        typed;    // expectation written in the row
    logic        answer;   // typed row produces one beat
    logic [1:0]  kind;
    logic [7:0]  tid;
    logic [47:0] at;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [27:0] cfg_data = '0;

  periodic_timer_queue dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mirror of the timer table and its scale registers.
  logic [15:0]      scale_sec;
  logic [21:0]      scale_min;
  logic [27:0]      scale_hour;
  logic [NOW_W-1:0] clock_ms;
  logic             tbl_valid    [SLOTS];
  logic [1:0]       tbl_kind     [SLOTS];
  logic [7:0]       tbl_task_id  [SLOTS];
  logic [NOW_W-1:0] tbl_deadline [SLOTS];
  logic [PER_W-1:0] tbl_period   [SLOTS];

  result_t awaited_events [$];
  result_t step_results   [$];

  int  mismatches = 0;
  int  beats_checked = 0;
  int  firings_seen = 0;
  int  rejects_seen = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still awaited", cycle_count,
               awaited_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Every strobed beat must match the oldest awaited one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (awaited_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected beat: kind %0d task %0d time %0d last %0d",
                   result.kind, result.task_id_out, result.event_time, result.last);
      end else begin
        want = awaited_events.pop_front();
        beats_checked++;
        if (want.kind == KIND_FIRED) firings_seen++;
        if (want.kind == KIND_REJECTED) rejects_seen++;
        if (result.kind !== want.kind || result.task_id_out !== want.task_id_out ||
            result.event_time !== want.event_time || result.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected kind %0d task %0d time %0d last %0d, %s",
                     want.kind, want.task_id_out, want.event_time, want.last,
                     $sformatf("got kind %0d task %0d time %0d last %0d",
                               result.kind, result.task_id_out, result.event_time,
                               result.last));
        end
      end
    end
  end

  // Applies one command to the mirror and leaves its beats in step_results.
  function automatic void timer_table_step(cmd_t c);
    logic [27:0]      scale;
    int               free_slot;
    int               best;
    int               fired;
    bit               more;
    logic             due  [SLOTS];
    logic [NOW_W-1:0] snap [SLOTS];
    result_t          r;
    step_results.delete();
    case (c.unit)
      UNIT_SECOND: scale = {12'd0, scale_sec};
      UNIT_MINUTE: scale = {6'd0, scale_min};
      default:     scale = scale_hour;
    endcase
    if (c.op != OP_TICK) begin
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      r.kind        = (free_slot < 0) ? KIND_REJECTED : KIND_ACCEPTED;
      r.task_id_out = c.task_id;
      r.event_time  = clock_ms;
      r.last        = 1'b1;
      if (free_slot >= 0) begin
        tbl_valid[free_slot]    = 1'b1;
        tbl_kind[free_slot]     = c.op;
        tbl_task_id[free_slot]  = c.task_id;
        tbl_deadline[free_slot] = clock_ms + 48'(c.initial_delay) * 48'(scale);
        tbl_period[free_slot]   = (c.op == OP_ONE_SHOT) ? '0 :
                                  40'(c.period) * 40'(scale);
      end
      step_results.push_back(r);
    end else begin
      clock_ms = clock_ms + 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        due[i]  = tbl_valid[i] && (tbl_deadline[i] <= clock_ms);
        snap[i] = tbl_deadline[i];
      end
      fired = 0;
      more  = 1'b1;
      // Earliest deadline first; a strict compare keeps ties on the lower slot.
      while (more && fired < MAX_RES) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (due[i] && (best < 0 || snap[i] < snap[best])) best = i;
        if (best < 0) begin
          more = 1'b0;
        end else begin
          due[best] = 1'b0;
          r.kind        = KIND_FIRED;
          r.task_id_out = tbl_task_id[best];
          r.event_time  = clock_ms;
          r.last        = 1'b0;
          step_results.push_back(r);
          fired++;
          case (tbl_kind[best])
            OP_FIXED_RATE:  tbl_deadline[best] = snap[best] + 48'(tbl_period[best]);
            OP_FIXED_DELAY: tbl_deadline[best] = clock_ms + 48'(tbl_period[best]);
            default:        tbl_valid[best] = 1'b0;
          endcase
        end
      end
      if (fired > 0) begin
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
      end
    end
  endfunction

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) idle_gap = 0;
    else if (roll < 92)       idle_gap = $urandom_range(1, 3);
    else                      idle_gap = $urandom_range(8, 40);
  endfunction

  function automatic cmd_t random_cmd(int max_delay, int periodic_pct);
    cmd_t c;
    int   pick;
    int   span;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 99);
    c.task_id       = 8'($urandom);
    c.initial_delay = 10'($urandom_range(0, max_delay));
    c.unit          = 2'($urandom_range(0, 3));
    if (span < 15)      c.period = '0;
    else if (span < 95) c.period = 10'($urandom_range(1, 7));
    else                c.period = 10'($urandom);
    if (pick < 45)
      c.op = OP_TICK;
    else if (pick < 45 + periodic_pct)
      c.op = $urandom_range(0, 1) ? OP_FIXED_RATE : OP_FIXED_DELAY;
    else
      c.op = OP_ONE_SHOT;
    random_cmd = c;
  endfunction

  // Leaves start high after its beat; the caller lowers it when the stream pauses.
  task automatic send_item(cmd_t c, bit push_model);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    timer_table_step(c);
    items_sent++;
    if (push_model)
      foreach (step_results[k]) awaited_events.push_back(step_results[k]);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [27:0] data);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MS_PER_SECOND: scale_sec  = data[15:0];
      CFG_MS_PER_MINUTE: scale_min  = data[21:0];
      CFG_MS_PER_HOUR:   scale_hour = data;
      default: ;  // unknown index is dropped
    endcase
    cfg_writes++;
  endtask

  // Junk above each register's width must be masked off by the block.
  task automatic apply_scales(logic [15:0] sec, logic [21:0] mins, logic [27:0] hours);
    cfg_write(CFG_MS_PER_SECOND, {12'($urandom), sec});
    cfg_write(CFG_UNUSED, 28'($urandom));
    cfg_write(CFG_MS_PER_MINUTE, {6'($urandom), mins});
    cfg_write(CFG_MS_PER_HOUR, hours);
    cfg_valid <= 1'b0;
  endtask

  // A tick that fires nothing gives no beat, so wait out its sweep as well.
  task automatic settle_idle();
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    dir_row_t    directed [DIR_ROWS];
    logic [15:0] sec_v;
    logic [21:0] min_v;
    logic [27:0] hour_v;
    int          max_delay;
    int          periodic_pct;

    directed = '{
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b1, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_ONE_SHOT, 8'h00, 10'd0, 10'd0, UNIT_SECOND},
        1'b1, 1'b1, KIND_ACCEPTED, 8'h00, 48'd1},
      '{'{OP_ONE_SHOT, 8'hFF, 10'd1023, 10'd1023, UNIT_THREE},
        1'b1, 1'b1, KIND_ACCEPTED, 8'hFF, 48'd1},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b1, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_FIXED_RATE, 8'h11, 10'd2, 10'd3, UNIT_HOUR},
        1'b1, 1'b1, KIND_ACCEPTED, 8'h11, 48'd3},
      '{'{OP_FIXED_DELAY, 8'h22, 10'd0, 10'd1023, UNIT_MINUTE},
        1'b1, 1'b1, KIND_ACCEPTED, 8'h22, 48'd3},
      '{'{OP_ONE_SHOT, 8'h33, 10'd7, 10'd5, UNIT_SECOND},
        1'b1, 1'b1, KIND_ACCEPTED, 8'h33, 48'd3},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_FIXED_DELAY, 8'h44, 10'd1, 10'd0, UNIT_HOUR},
        1'b1, 1'b1, KIND_ACCEPTED, 8'h44, 48'd5},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0},
      '{'{OP_FIXED_RATE, 8'h55, 10'd1, 10'd1, UNIT_HOUR},
        1'b1, 1'b1, KIND_ACCEPTED, 8'h55, 48'd8},
      '{'{OP_TICK, 8'h00, 10'd0, 10'd0, UNIT_SECOND}, 1'b0, 1'b0, KIND_FIRED, 8'h00, 48'd0}
    };

    scale_sec  = MS_PER_SECOND_RST;
    scale_min  = MS_PER_MINUTE_RST;
    scale_hour = MS_PER_HOUR_RST;
    clock_ms   = '0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset scales first, then zero seconds, widest minutes and one-ms hours.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == CFG_ROW) begin
        start <= 1'b0;
        settle_idle();
        apply_scales(16'd0, 22'h3FFFFF, 28'd1);
      end
      send_item(directed[i].c, !directed[i].typed);
      if (directed[i].typed && directed[i].answer)
        awaited_events.push_back('{directed[i].kind, directed[i].tid, directed[i].at, 1'b1});
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          sec_v = 16'd1; min_v = 22'd2; hour_v = 28'd3; max_delay = 8; periodic_pct = 4;
        end
        1: begin
          sec_v = 16'd0; min_v = 22'd1; hour_v = 28'd5; max_delay = 15; periodic_pct = 4;
        end
        2: begin
          // Widest scales: only immediate one-shots, or the table would clog.
          sec_v = 16'hFFFF; min_v = 22'h3FFFFF; hour_v = 28'hFFFFFFF;
          max_delay = 0; periodic_pct = 0;
        end
        3: begin
          sec_v = 16'd2; min_v = 22'd1; hour_v = 28'd4; max_delay = 31; periodic_pct = 6;
        end
        default: begin
          sec_v = 16'd1; min_v = 22'd1; hour_v = 28'd1; max_delay = 63; periodic_pct = 4;
        end
      endcase
      start <= 1'b0;
      settle_idle();
      apply_scales(sec_v, min_v, hour_v);
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        no_idle = ((item / 24) % 3) == 2;
        send_item(random_cmd(max_delay, periodic_pct), 1'b1);
      end
    end

    start <= 1'b0;
    settle_idle();
    $display("Run covered %0d commands and %0d register writes over %0d scale settings.",
             items_sent, cfg_writes, PHASES + 2);
    $display("Checked %0d result beats: %0d timer firings, %0d table-full rejections.",
             beats_checked, firings_seen, rejects_seen);
    if (mismatches == 0 && awaited_events.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
rtl/ptq_pkg.sv
rtl/ptq_slot_mem.sv
rtl/ptq_arm.sv
rtl/periodic_timer_queue.sv
tb/testbench.sv
